/* rtl/sabd_pkg.sv */
// Shared types, constants and helpers for the sliding-window checksum digest.
// Used by every module of the block; depends on nothing else.
package sabd_pkg;

    localparam int MAX_WORDS  = 64;
    localparam int WORDS_W    = 7;
    localparam int IDX_W      = 6;
    localparam int DWORD_W    = 32;
    localparam int SUM_W      = 16;
    localparam int BITPOS_W   = 5;
    localparam int QUO_W      = 2 * SUM_W - BITPOS_W;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = (QUO_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [WORDS_W-1:0] WORDS_RESET = WORDS_W'(MAX_WORDS);

    // One queued job for the back end: an optional bit set and an optional emit.
    typedef struct packed {
        logic                   hash;
        logic                   last;
        logic [2*SUM_W-1:0]     sum;
        logic [WORDS_W-1:0]     words;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SET_RD,
        ST_SET_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_back_state;

    // A size of zero acts as one word, anything above the store acts as the full store.
    function automatic logic [WORDS_W-1:0] clamp_words(input logic [WORDS_W-1:0] w);
        logic [WORDS_W-1:0] r;
        r = w;
        if (w == '0) begin
            r = WORDS_W'(1);
        end else if (w > WORDS_W'(MAX_WORDS)) begin
            r = WORDS_W'(MAX_WORDS);
        end
        return r;
    endfunction

endpackage

/* rtl/sabd_queue.sv */
// Small command queue between the byte front end and the digest back end.
// Depends on sabd_pkg for the command type and depth.
module sabd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sabd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sabd_pkg::t_cmd o_head
);
    import sabd_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/sabd_front.sv */
// Byte front end: keeps the window and rolling sums, forms the checksum per byte
// and queues hash and emit jobs. Depends on sabd_pkg.
module sabd_front #(
    parameter int WINDOW = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    input  logic [sabd_pkg::WORDS_W-1:0]   i_words,
    input  logic                           i_q_full,
    output logic                           o_stall,
    output logic                           o_push,
    output sabd_pkg::t_cmd                 o_cmd
);
    import sabd_pkg::*;

    localparam int HELD   = WINDOW - 1;
    localparam int SEEN_W = $clog2(WINDOW);

    logic [7:0]         r_win [HELD];
    logic [SEEN_W-1:0]  r_seen;
    logic [SUM_W-1:0]   r_s;
    logic [SUM_W-1:0]   r_t;
    logic [SUM_W-1:0]   lo;
    logic [SUM_W-1:0]   hi;
    logic [SUM_W-1:0]   drop;
    logic               accept;
    logic               full_window;

    // r_s is the plain sum of the held bytes, r_t their sum weighted WINDOW-1 down to 1
    // (oldest heaviest). Both sums stay far below 65521, so no reduction is needed.
    assign drop        = SUM_W'(r_win[0]);
    assign lo          = r_s + SUM_W'(i_data_byte);
    assign hi          = r_t + lo;
    assign full_window = (r_seen == SEEN_W'(HELD));
    assign accept      = i_valid && !i_q_full;

    assign o_stall     = i_q_full;
    assign o_push      = accept && (full_window || i_last_byte);
    assign o_cmd.hash  = full_window;
    assign o_cmd.last  = i_last_byte;
    assign o_cmd.sum   = {hi, lo};
    assign o_cmd.words = i_words;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HELD; i++) begin
                r_win[i] <= '0;
            end
            r_seen <= '0;
            r_s    <= '0;
            r_t    <= '0;
        end else if (accept) begin
            if (i_last_byte) begin
                for (int i = 0; i < HELD; i++) begin
                    r_win[i] <= '0;
                end
                r_seen <= '0;
                r_s    <= '0;
                r_t    <= '0;
            end else begin
                for (int i = 0; i < HELD - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[HELD-1] <= i_data_byte;
                if (!full_window) begin
                    r_seen <= r_seen + SEEN_W'(1);
                end
                r_s <= lo - drop;
                r_t <= hi - SUM_W'(SUM_W'(WINDOW) * drop);
            end
        end
    end

endmodule

/* rtl/sabd_back.sv */
// Digest back end: reduces each checksum modulo the bit count with a radix-16
// remainder unit, sets the bit in the store and streams the digest out.
// Depends on sabd_pkg.
module sabd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  sabd_pkg::t_cmd                 i_q_head,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sabd_pkg::DWORD_W-1:0]   o_digest_word,
    output logic [sabd_pkg::IDX_W-1:0]     o_word_index,
    output logic                           o_last_word
);
    import sabd_pkg::*;

    t_back_state             r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [DIV_W-1:0]        r_div_x, n_div_x;
    logic [IDX_W-1:0]        r_rem, n_rem;
    logic [DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]        r_k, n_k;

    logic [DWORD_W-1:0]      mem [MAX_WORDS];
    logic [MAX_WORDS-1:0]    r_valid;
    logic [DWORD_W-1:0]      r_rd_data;
    logic                    r_rd_vld;
    logic [DWORD_W-1:0]      rd_word;

    logic                    mem_re;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_addr;
    logic [DWORD_W-1:0]      mem_wdata;
    logic                    clr_all;

    logic                    r_out_valid;
    logic [DWORD_W-1:0]      r_out_word;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_last;
    logic                    out_free;
    logic                    out_load;
    logic                    k_is_last;

    logic [IDX_W-1:0]        step_rem;
    logic [DIV_W-1:0]        step_x;
    logic [WORDS_W-1:0]      step_t;

    assign rd_word   = r_rd_vld ? r_rd_data : '0;
    assign out_free  = !r_out_valid || !i_stall;
    assign k_is_last = ((WORDS_W'(r_k) + WORDS_W'(1)) == r_cmd.words);

    // Four restoring remainder steps per cycle, most significant bits first.
    always_comb begin
        step_rem = r_rem;
        step_x   = r_div_x;
        step_t   = '0;
        for (int j = 0; j < DIV_STEP; j++) begin
            step_t = {step_rem, step_x[DIV_W-1]};
            step_x = {step_x[DIV_W-2:0], 1'b0};
            if (step_t >= r_cmd.words) begin
                step_t = step_t - r_cmd.words;
            end
            step_rem = step_t[IDX_W-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_div_x   = r_div_x;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_k       = r_k;
        o_q_pop   = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = r_rem;
        mem_wdata = rd_word | (DWORD_W'(1) << r_cmd.sum[BITPOS_W-1:0]);
        clr_all   = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_div_x = DIV_W'(i_q_head.sum[2*SUM_W-1:BITPOS_W]);
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_k     = '0;
                    n_state = i_q_head.hash ? ST_DIV : ST_EMIT_RD;
                end
            end
            ST_DIV: begin
                n_div_x = step_x;
                n_rem   = step_rem;
                n_cnt   = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    n_state = ST_SET_RD;
                end
            end
            ST_SET_RD: begin
                mem_re  = 1'b1;
                n_state = ST_SET_WR;
            end
            ST_SET_WR: begin
                mem_we  = 1'b1;
                n_state = r_cmd.last ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD: begin
                mem_re   = 1'b1;
                mem_addr = r_k;
                n_state  = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                mem_addr = r_k;
                if (out_free) begin
                    out_load = 1'b1;
                    if (k_is_last) begin
                        // Words past the current size are dropped as well.
                        clr_all = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_div_x <= n_div_x;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_k     <= n_k;
        if (out_load) begin
            r_out_word <= rd_word;
            r_out_idx  <= r_k;
            r_out_last <= k_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_re) begin
                r_rd_vld <= r_valid[mem_addr];
            end
            if (clr_all) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[mem_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = r_out_last;

endmodule

/* rtl/sliding_adler_bloom_digest.sv */
// Top level of the sliding-window checksum digest: size register, front end,
// job queue and back end. Depends on sabd_pkg, sabd_front, sabd_queue, sabd_back.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+------------------------------------------
//  in      | into      | i_valid / o_stall      | i_data_byte, i_last_byte
//  out     | out of    | o_valid / i_stall      | o_digest_word, o_word_index, o_last_word
//  cfg     | into      | i_cfg_valid/o_cfg_ready| i_cfg_data (digest size in 32-bit words)
//
// A byte that completes no window and is not final queues no job for the back end.
// A byte that hashes costs the back end a queue pop, the remainder steps of the radix-16
// unit and a read-modify-write of the store; a 4-deep queue absorbs bursts.
// A final byte adds, for each digest word, a read of the store port and an output load.
// Reset is synchronous and needs no clearing pass; per-word valid bits empty the store.
// Input stalls only when the queue is full; output stalls hold the word in its register.
module sliding_adler_bloom_digest #(
    parameter int WINDOW = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sabd_pkg::DWORD_W-1:0]   o_digest_word,
    output logic [sabd_pkg::IDX_W-1:0]     o_word_index,
    output logic                           o_last_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sabd_pkg::WORDS_W-1:0]   i_cfg_data
);
    import sabd_pkg::*;

    logic [WORDS_W-1:0] r_digest_words;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    t_cmd               q_in;
    t_cmd               q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digest_words <= WORDS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_digest_words <= i_cfg_data;
        end
    end

    sabd_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_words     (clamp_words(r_digest_words)),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    sabd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    sabd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

/* rtl/sabd_checker.sv */
// Port-level checks on the digest output channel, bound to the top level.
// Depends on sabd_pkg and sliding_adler_bloom_digest.
module sabd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [sabd_pkg::DWORD_W-1:0]   o_digest_word,
    input logic [sabd_pkg::IDX_W-1:0]     o_word_index,
    input logic                           o_last_word
);
    import sabd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_digest_word) && $stable(o_word_index)
                               && $stable(o_last_word))
        else $error("stalled output word changed");

    a_top_index_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word_index == IDX_W'(MAX_WORDS - 1)) |-> o_last_word)
        else $error("highest word index not marked last");

    a_known_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_digest_word, o_word_index, o_last_word}))
        else $error("output word carries unknown bits");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid survived reset");

endmodule

bind sliding_adler_bloom_digest sabd_checker u_sabd_checker (.*);

/* sim/sliding_adler_bloom_digest_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sliding_adler_bloom_digest: byte messages in, digest words out.
// Depends on sabd_pkg and the RTL of the block; a built-in predictor supplies expected words.
module sliding_adler_bloom_digest_tb;

    localparam int WIN        = 4;
    localparam int ADLER_BASE = 65521;
    localparam int SETTLE     = 64;

    typedef struct {
        logic [sabd_pkg::DWORD_W-1:0] data;
        logic [sabd_pkg::IDX_W-1:0]   index;
        logic                         last;
    } t_digest_word;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic [7:0]                   i_data_byte = 8'h00;
    logic                         i_last_byte = 1'b0;
    logic                         i_stall     = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic [sabd_pkg::WORDS_W-1:0] i_cfg_data  = '0;
    logic                         o_stall;
    logic                         o_valid;
    logic [sabd_pkg::DWORD_W-1:0] o_digest_word;
    logic [sabd_pkg::IDX_W-1:0]   o_word_index;
    logic                         o_last_word;
    logic                         o_cfg_ready;

    // Predictor state.
    logic [7:0]                   win_bytes [WIN-1];
    int unsigned                  win_fill;
    logic [31:0]                  digest_bits [sabd_pkg::MAX_WORDS];
    logic [sabd_pkg::WORDS_W-1:0] size_words;
    t_digest_word                 pending_words [$];

    // Traffic shaping.
    t_rx_mode rx_mode     = RX_FREE;
    int       rx_phase    = 0;
    logic     hold_active = 1'b0;
    int       hold_len    = 0;
    event     hold_go;
    bit       gaps_on     = 1'b0;
    int       burst_left  = 0;

    int errors        = 0;
    int bytes_sent    = 0;
    int messages_sent = 0;
    int words_checked = 0;
    int size_writes   = 0;

    sliding_adler_bloom_digest dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d digest words still expected.", pending_words.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Updates the predicted digest with one byte and queues the words a final byte releases.
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        int unsigned  words;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  bitpos;
        t_digest_word w;
        words = size_words;
        if (words == 0) begin
            words = 1;
        end else if (words > sabd_pkg::MAX_WORDS) begin
            words = sabd_pkg::MAX_WORDS;
        end
        if (win_fill >= WIN - 1) begin
            lo = 0;
            hi = 0;
            for (int i = 0; i < WIN - 1; i++) begin
                lo += win_bytes[i];
                hi += lo;
            end
            lo += b;
            hi += lo;
            lo = lo % ADLER_BASE;
            hi = hi % ADLER_BASE;
            bitpos = (((hi & 32'hffff) << 16) | (lo & 32'hffff)) % (words * 32);
            digest_bits[bitpos / 32][bitpos % 32] = 1'b1;
        end
        for (int i = 0; i < WIN - 2; i++) begin
            win_bytes[i] = win_bytes[i + 1];
        end
        win_bytes[WIN - 2] = b;
        if (win_fill < WIN - 1) begin
            win_fill++;
        end
        if (last) begin
            for (int k = 0; k < words; k++) begin
                w.data  = digest_bits[k];
                w.index = sabd_pkg::IDX_W'(k);
                w.last  = (k == words - 1);
                pending_words.push_back(w);
            end
            digest_bits = '{default: '0};
            win_bytes   = '{default: '0};
            win_fill    = 0;
            messages_sent++;
        end
    endfunction

    // Each accepted word is compared with the oldest predicted word.
    always @(posedge i_clk) begin : check_words
        t_digest_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual %h index %0d last %b",
                         $time, o_digest_word, o_word_index, o_last_word);
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (o_digest_word !== want.data) begin
                    errors++;
                    $display("%0t: digest_word expected %h actual %h (index %0d)",
                             $time, want.data, o_digest_word, want.index);
                end
                if (o_word_index !== want.index) begin
                    errors++;
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, want.index, o_word_index);
                end
                if (o_last_word !== want.last) begin
                    errors++;
                    $display("%0t: last_word expected %b actual %b (index %0d)",
                             $time, want.last, o_last_word, want.index);
                end
            end
        end
    end

    // Receiver stall pattern, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin : drive_rx_stall
        logic pat;
        case (rx_mode)
            RX_FREE: begin
                pat = 1'b0;
            end
            RX_RANDOM: begin
                pat = ($urandom_range(0, 3) == 0);
            end
            default: begin
                pat = (rx_phase < 3);
                rx_phase = (rx_phase == 6) ? 0 : rx_phase + 1;
            end
        endcase
        i_stall <= pat | hold_active;
    end

    always begin
        @(hold_go);
        @(posedge i_clk);
        hold_active = 1'b1;
        repeat (hold_len) @(posedge i_clk);
        hold_active = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        absorb_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(rand_byte(), i == len - 1);
        end
    endtask

    // Waits until every predicted word has arrived and any queued hash work has drained.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [sabd_pkg::WORDS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        size_words = v;
        size_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return 8'h00;
        end else if (sel == 1) begin
            return 8'hff;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [sabd_pkg::WORDS_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return sabd_pkg::WORDS_W'($urandom_range(9, 64));
        end else if (sel == 2) begin
            return sabd_pkg::WORDS_W'($urandom_range(65, 127));
        end
        return sabd_pkg::WORDS_W'($urandom_range(1, 8));
    endfunction

    // Reset size, all-ones and all-zeros bytes, final byte completing a window.
    task automatic test_default_size();
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // Messages too short to fill a window still emit an empty digest.
    task automatic test_short_messages();
        send_message(1);
        send_message(2);
        send_message(3);
        wait_idle();
    endtask

    task automatic test_size_clamp();
        write_size('0);
        send_message(4);
        wait_idle();
        write_size(7'd127);
        send_message(4);
        wait_idle();
    endtask

    // Bits placed past the new size must be dropped when the size shrinks mid-message.
    task automatic test_size_change_mid_message();
        write_size(7'd64);
        for (int i = 0; i < 5; i++) begin
            send_byte(rand_byte(), 1'b0);
        end
        wait_idle();
        write_size(7'd1);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
    endtask

    // Long output hold-off while input keeps coming, so the job queue fills.
    task automatic test_output_backpressure();
        write_size(7'd4);
        rx_mode  = RX_FREE;
        gaps_on  = 1'b0;
        hold_len = 400;
        -> hold_go;
        for (int m = 0; m < 3; m++) begin
            send_message(10);
        end
        wait_idle();
    endtask

    task automatic test_random_messages(input int target);
        int start;
        int len;
        int sel;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            write_size(pick_size());
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            gaps_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(3, 8)) begin
                sel = $urandom_range(0, 19);
                if (sel < 3) begin
                    len = $urandom_range(1, 3);
                end else if (sel < 5) begin
                    len = $urandom_range(17, 40);
                end else begin
                    len = $urandom_range(4, 16);
                end
                send_message(len);
            end
            // Sometimes leave a message open so the next size applies mid-message.
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 8)) send_byte(rand_byte(), 1'b0);
            end
            wait_idle();
        end
    endtask

    initial begin
        win_bytes   = '{default: '0};
        win_fill    = 0;
        digest_bits = '{default: '0};
        size_words  = sabd_pkg::WORDS_RESET;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_size();
        test_short_messages();
        test_size_clamp();
        test_size_change_mid_message();
        test_output_backpressure();
        test_random_messages(500);
        send_message(4);

        wait_idle();
        $display("Sent %0d bytes in %0d messages over %0d size settings.",
                 bytes_sent, messages_sent, size_writes);
        $display("Compared %0d digest words, %0d mismatching fields.", words_checked, errors);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sliding_adler_bloom_digest.f */
rtl/sabd_pkg.sv
rtl/sabd_queue.sv
rtl/sabd_front.sv
rtl/sabd_back.sv
rtl/sliding_adler_bloom_digest.sv
rtl/sabd_checker.sv
sim/sliding_adler_bloom_digest_tb.sv
